>>> rtl/core/mfsp_pkg.sv
// Package: constants and types shared by the five-stage pipeline block and its testbench.
`default_nettype none
package mfsp_pkg;
  localparam int REG_COUNT_DEF  = 32;
  localparam int DMEM_WORDS_DEF = 8;
  localparam int PC_BITS_DEF    = 16;

  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_LW    = 6'b100011;
  localparam logic [5:0] OP_SW    = 6'b101011;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] FN_ADD   = 6'b100000;
  localparam logic [5:0] FN_SUB   = 6'b100010;
  localparam logic [5:0] FN_AND   = 6'b100100;
  localparam logic [5:0] FN_OR    = 6'b100101;
  localparam logic [5:0] FN_SLT   = 6'b101010;

  localparam logic [2:0] ALU_AND = 3'd0;
  localparam logic [2:0] ALU_OR  = 3'd1;
  localparam logic [2:0] ALU_ADD = 3'd2;
  localparam logic [2:0] ALU_SUB = 3'd6;
  localparam logic [2:0] ALU_SLT = 3'd7;

  // result fields, highest bits first
  typedef struct packed {
    logic [31:0] store_data;
    logic [2:0]  store_index;
    logic        store_valid;
    logic [31:0] wb_data;
    logic [4:0]  wb_reg;
    logic        wb_valid;
    logic        branch_taken;
    logic        stall_res;
    logic [15:0] fetch_addr;
  } res_t;

  function automatic logic [31:0] reg_init(input int i);
    case (i)
      1: reg_init = 32'd9;
      2: reg_init = 32'd8;
      3: reg_init = 32'd7;
      4: reg_init = 32'd1;
      5: reg_init = 32'd2;
      6: reg_init = 32'd3;
      7: reg_init = 32'd4;
      8: reg_init = 32'd5;
      9: reg_init = 32'd6;
      default: reg_init = 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] mem_init(input int i);
    case (i)
      0: mem_init = 32'd5;
      1: mem_init = 32'd9;
      2: mem_init = 32'd4;
      3: mem_init = 32'd8;
      4: mem_init = 32'd7;
      default: mem_init = 32'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/mips_five_stage_pipeline.sv
// Top level: five-stage MIPS pipeline with forwarding, one pipeline step per transaction.
//
// Input channel in_*: each transaction is one pipeline step. in_tdata carries the
// instruction word fetched at the last reported fetch address, in_tuser says whether
// it is present (0 fetches a bubble). The pipeline advances only when a transaction
// is accepted.
// Output channel out_*: one result per input transaction, holding the next fetch
// address, stall and branch flags, the writeback and the store of that cycle.
// The result of an accepted transaction is registered in the output or skid register.
// Throughput: one transaction per cycle while in_tready is high; the pipeline step is
// a single pass of logic between the stage latches and the output register, which a
// one-entry skid stage decouples from the receiver.
// Reset (rst_n low): PC zero, all stage latches empty, register file and data
// memory loaded with their initial contents, no result pending.
// Receiver stall: in_tready drops once the skid stage is also full, holding all state.
`default_nettype none
module mips_five_stage_pipeline #(
  parameter int REG_COUNT  = mfsp_pkg::REG_COUNT_DEF,
  parameter int DMEM_WORDS = mfsp_pkg::DMEM_WORDS_DEF,
  parameter int PC_BITS    = mfsp_pkg::PC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,  // instr_word
  input  wire logic         in_tuser,  // instr_valid
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // fetch_addr[15:0] stall_res[16] branch_taken[17] wb_valid[18] wb_reg[23:19]
  // wb_data[55:24] store_valid[56] store_index[59:57] store_data[91:60], pad to 96
  output logic [95:0]       out_tdata
);
  localparam int DW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;

  mfsp_pkg::res_t res_nxt, res_r, skid_r;
  logic out_v_r, skid_v_r;
  logic go;

  logic [PC_BITS-1:0] pc_r, pc_nxt;
  // IF/ID
  logic fd_v_r; logic [31:0] fd_i_r; logic [PC_BITS-1:0] fd_pc4_r;
  // ID/EX
  logic de_rw_r, de_m2r_r, de_mr_r, de_mw_r, de_br_r, de_src_r, de_dst_r;
  logic [2:0] de_alu_r; logic [31:0] de_rd1_r, de_rd2_r, de_imm_r;
  logic [PC_BITS-1:0] de_pc4_r; logic [4:0] de_rs_r, de_rt_r, de_rd_r;
  // EX/MEM
  logic em_rw_r, em_m2r_r, em_mr_r, em_mw_r, em_br_r;
  logic [31:0] em_alu_r, em_wd_r; logic [PC_BITS-1:0] em_tgt_r; logic [4:0] em_dst_r;
  // MEM/WB
  logic mw_rw_r, mw_m2r_r; logic [31:0] mw_rd_r, mw_alu_r; logic [4:0] mw_dst_r;

  logic [31:0] rf_r [REG_COUNT];
  logic [31:0] dm_r [DMEM_WORDS];

  assign in_tready  = !skid_v_r;
  assign go         = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, res_r};

  // combinational step
  logic [31:0] mw_val, a, b, bsel, alu_v, imm_d, rd1_d, rd2_d;
  logic wb_en, taken, stall, ld_hit, st_en, idx_ok;
  logic [29:0] idx;
  logic [5:0] op, fn;
  logic [4:0] frs, frt, frd;
  logic dv, d_rw, d_m2r, d_mr, d_mw, d_br, d_src, d_dst;
  logic [2:0] d_alu;

  always_comb begin
    mw_val = mw_m2r_r ? mw_rd_r : mw_alu_r;
    wb_en  = mw_rw_r && (mw_dst_r != 5'd0) && (32'(mw_dst_r) < REG_COUNT);
    idx    = em_alu_r[31:2];
    idx_ok = 32'(idx) < DMEM_WORDS;
    taken  = em_br_r && (em_alu_r == 32'd0);
    st_en  = !taken && !em_mr_r && em_mw_r && idx_ok;
    ld_hit = idx_ok;

    a = de_rd1_r;
    if (em_rw_r && em_dst_r != 5'd0 && em_dst_r == de_rs_r) a = em_alu_r;
    else if (mw_rw_r && mw_dst_r != 5'd0 && mw_dst_r == de_rs_r) a = mw_val;
    b = de_rd2_r;
    if (em_rw_r && em_dst_r != 5'd0 && em_dst_r == de_rt_r) b = em_alu_r;
    else if (mw_rw_r && mw_dst_r != 5'd0 && mw_dst_r == de_rt_r) b = mw_val;
    bsel = de_src_r ? de_imm_r : b;
    case (de_alu_r)
      mfsp_pkg::ALU_AND: alu_v = a & bsel;
      mfsp_pkg::ALU_OR:  alu_v = a | bsel;
      mfsp_pkg::ALU_SUB: alu_v = a - bsel;
      mfsp_pkg::ALU_SLT: alu_v = {31'd0, $signed(a) < $signed(bsel)};
      default:           alu_v = a + bsel;
    endcase

    op  = fd_i_r[31:26];
    fn  = fd_i_r[5:0];
    frs = fd_i_r[25:21];
    frt = fd_i_r[20:16];
    frd = fd_i_r[15:11];
    imm_d = {{16{fd_i_r[15]}}, fd_i_r[15:0]};
    rd1_d = (frs == 5'd0 || 32'(frs) >= REG_COUNT) ? 32'd0 : rf_r[frs[$clog2(REG_COUNT)-1:0]];
    rd2_d = (frt == 5'd0 || 32'(frt) >= REG_COUNT) ? 32'd0 : rf_r[frt[$clog2(REG_COUNT)-1:0]];
    // writeback happens before decode reads
    if (wb_en && mw_dst_r == frs) rd1_d = mw_val;
    if (wb_en && mw_dst_r == frt) rd2_d = mw_val;

    dv = fd_v_r;
    {d_rw, d_m2r, d_mr, d_mw, d_br, d_src, d_dst} = '0;
    d_alu = mfsp_pkg::ALU_AND;
    if (fd_v_r) begin
      case (op)
        mfsp_pkg::OP_RTYPE: begin
          d_rw = 1'b1; d_dst = 1'b1;
          case (fn)
            mfsp_pkg::FN_ADD: d_alu = mfsp_pkg::ALU_ADD;
            mfsp_pkg::FN_SUB: d_alu = mfsp_pkg::ALU_SUB;
            mfsp_pkg::FN_AND: d_alu = mfsp_pkg::ALU_AND;
            mfsp_pkg::FN_OR:  d_alu = mfsp_pkg::ALU_OR;
            mfsp_pkg::FN_SLT: d_alu = mfsp_pkg::ALU_SLT;
            default: begin
              d_rw = 1'b0; d_dst = 1'b0;
            end
          endcase
        end
        mfsp_pkg::OP_LW: begin
          d_alu = mfsp_pkg::ALU_ADD; d_src = 1'b1; d_mr = 1'b1; d_rw = 1'b1; d_m2r = 1'b1;
        end
        mfsp_pkg::OP_SW: begin
          d_alu = mfsp_pkg::ALU_ADD; d_src = 1'b1; d_mw = 1'b1;
        end
        mfsp_pkg::OP_BEQ: begin
          d_alu = mfsp_pkg::ALU_SUB; d_br = 1'b1;
        end
        default: ;
      endcase
    end

    stall = de_mr_r && de_rt_r != 5'd0 && fd_v_r && (de_rt_r == frs || de_rt_r == frt)
            && !taken;

    if (taken) pc_nxt = em_tgt_r;
    else if (stall) pc_nxt = pc_r;
    else pc_nxt = pc_r + PC_BITS'(4);

    res_nxt.fetch_addr   = 16'(32'(pc_nxt));
    res_nxt.stall_res    = stall;
    res_nxt.branch_taken = taken;
    res_nxt.wb_valid     = wb_en;
    res_nxt.wb_reg       = wb_en ? mw_dst_r : 5'd0;
    res_nxt.wb_data      = wb_en ? mw_val : 32'd0;
    res_nxt.store_valid  = st_en;
    res_nxt.store_index  = st_en ? idx[2:0] : 3'd0;
    res_nxt.store_data   = st_en ? em_wd_r : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (out_v_r && !out_tready) begin
        if (go) begin
          skid_v_r <= 1'b1;
          skid_r   <= res_nxt;
        end
      end else if (skid_v_r) begin
        res_r    <= skid_r;
        skid_v_r <= 1'b0;
        out_v_r  <= 1'b1;
      end else begin
        out_v_r <= go;
        if (go) res_r <= res_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      fd_v_r <= 1'b0; fd_i_r <= '0; fd_pc4_r <= '0;
      {de_rw_r, de_m2r_r, de_mr_r, de_mw_r, de_br_r, de_src_r, de_dst_r} <= '0;
      de_alu_r <= '0; de_rd1_r <= '0; de_rd2_r <= '0; de_imm_r <= '0; de_pc4_r <= '0;
      de_rs_r <= '0; de_rt_r <= '0; de_rd_r <= '0;
      {em_rw_r, em_m2r_r, em_mr_r, em_mw_r, em_br_r} <= '0;
      em_alu_r <= '0; em_wd_r <= '0; em_tgt_r <= '0; em_dst_r <= '0;
      mw_rw_r <= 1'b0; mw_m2r_r <= 1'b0; mw_rd_r <= '0; mw_alu_r <= '0; mw_dst_r <= '0;
      for (int i = 0; i < REG_COUNT; i++) rf_r[i] <= mfsp_pkg::reg_init(i);
      for (int i = 0; i < DMEM_WORDS; i++) dm_r[i] <= mfsp_pkg::mem_init(i);
    end else if (go) begin
      pc_r <= pc_nxt;
      if (wb_en) rf_r[mw_dst_r[$clog2(REG_COUNT)-1:0]] <= mw_val;
      if (st_en) dm_r[idx[DW-1:0]] <= em_wd_r;
      // MEM/WB
      mw_rw_r  <= em_rw_r;
      mw_m2r_r <= em_m2r_r;
      mw_alu_r <= em_alu_r;
      mw_dst_r <= em_dst_r;
      mw_rd_r  <= (!taken && em_mr_r && ld_hit) ? dm_r[idx[DW-1:0]] : 32'd0;
      // EX/MEM
      if (taken) begin
        {em_rw_r, em_m2r_r, em_mr_r, em_mw_r, em_br_r} <= '0;
        em_alu_r <= '0; em_wd_r <= '0; em_tgt_r <= '0; em_dst_r <= '0;
      end else begin
        em_rw_r <= de_rw_r; em_m2r_r <= de_m2r_r; em_mr_r <= de_mr_r;
        em_mw_r <= de_mw_r; em_br_r <= de_br_r;
        em_alu_r <= alu_v; em_wd_r <= b;
        em_dst_r <= de_dst_r ? de_rd_r : de_rt_r;
        em_tgt_r <= de_pc4_r + PC_BITS'({de_imm_r[29:0], 2'b00});
      end
      // ID/EX
      if (taken || stall || !dv) begin
        {de_rw_r, de_m2r_r, de_mr_r, de_mw_r, de_br_r, de_src_r, de_dst_r} <= '0;
        de_alu_r <= '0; de_rd1_r <= '0; de_rd2_r <= '0; de_imm_r <= '0; de_pc4_r <= '0;
        de_rs_r <= '0; de_rt_r <= '0; de_rd_r <= '0;
      end else begin
        de_rw_r <= d_rw; de_m2r_r <= d_m2r; de_mr_r <= d_mr; de_mw_r <= d_mw;
        de_br_r <= d_br; de_src_r <= d_src; de_dst_r <= d_dst; de_alu_r <= d_alu;
        de_rd1_r <= rd1_d; de_rd2_r <= rd2_d; de_imm_r <= imm_d;
        de_pc4_r <= fd_pc4_r; de_rs_r <= frs; de_rt_r <= frt; de_rd_r <= frd;
      end
      // IF/ID
      if (taken) begin
        fd_v_r <= 1'b0; fd_i_r <= '0; fd_pc4_r <= '0;
      end else if (!stall) begin
        fd_v_r   <= in_tuser;
        fd_i_r   <= in_tuser ? in_tdata : 32'd0;
        fd_pc4_r <= pc_nxt;
      end
    end
  end
endmodule
`default_nettype wire

>>> tb/sv/pipeline_checker.sv
// Checker: models the pipeline transaction by transaction and compares every output transaction.
`default_nettype none
module pipeline_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [95:0] out_tdata,
  output int               fail_count,
  output int               pending
);
  import mfsp_pkg::*;

  typedef struct {
    logic        fv;
    logic [31:0] finstr;
    logic [15:0] fpc4;
  } fd_s;
  typedef struct {
    logic regwrite, memtoreg, memread, memwrite, branch, alusrc, regdst;
    logic [2:0] aluctl;
    logic [31:0] rd1, rd2, imm;
    logic [15:0] pc4;
    logic [4:0] rs, rt, rd;
  } de_s;
  typedef struct {
    logic regwrite, memtoreg, memread, memwrite, branch;
    logic [31:0] alu, wdata;
    logic [15:0] target;
    logic [4:0] dst;
  } em_s;
  typedef struct {
    logic regwrite, memtoreg;
    logic [31:0] rdata, alu;
    logic [4:0] dst;
  } mw_s;

  logic [15:0] pc;
  fd_s fd;
  de_s de;
  em_s em;
  mw_s mw;
  logic [31:0] regs [32];
  logic [31:0] dmem [8];
  res_t expected_q [$];

  function automatic logic [31:0] alu_calc(logic [2:0] ctl, logic [31:0] a, logic [31:0] b);
    case (ctl)
      ALU_AND: return a & b;
      ALU_OR:  return a | b;
      ALU_SUB: return a - b;
      ALU_SLT: return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      default: return a + b;
    endcase
  endfunction

  function automatic de_s decode_word(fd_s f);
    de_s d;
    logic [5:0] op, fn;
    d = '{default: '0};
    op = f.finstr[31:26];
    fn = f.finstr[5:0];
    if (!f.fv) return d;
    d.rs = f.finstr[25:21];
    d.rt = f.finstr[20:16];
    d.rd = f.finstr[15:11];
    d.imm = {{16{f.finstr[15]}}, f.finstr[15:0]};
    d.pc4 = f.fpc4;
    d.rd1 = (d.rs == 0) ? 32'd0 : regs[d.rs];
    d.rd2 = (d.rt == 0) ? 32'd0 : regs[d.rt];
    if (op == OP_RTYPE) begin
      case (fn)
        FN_ADD: d.aluctl = ALU_ADD;
        FN_SUB: d.aluctl = ALU_SUB;
        FN_AND: d.aluctl = ALU_AND;
        FN_OR:  d.aluctl = ALU_OR;
        FN_SLT: d.aluctl = ALU_SLT;
        default: return d;
      endcase
      d.regdst = 1;
      d.regwrite = 1;
    end else if (op == OP_LW) begin
      d.aluctl = ALU_ADD; d.alusrc = 1; d.memread = 1; d.regwrite = 1; d.memtoreg = 1;
    end else if (op == OP_SW) begin
      d.aluctl = ALU_ADD; d.alusrc = 1; d.memwrite = 1;
    end else if (op == OP_BEQ) begin
      d.aluctl = ALU_SUB; d.branch = 1;
    end
    return d;
  endfunction

  task automatic advance_cycle(input logic [31:0] word, input logic present);
    res_t r;
    mw_s nmw;
    em_s nem;
    de_s nde;
    logic [31:0] a, b, mwv, idx;
    logic taken, stall;
    r = '0;
    taken = 0;
    stall = 0;
    mwv = mw.memtoreg ? mw.rdata : mw.alu;
    if (mw.regwrite && mw.dst != 0) begin
      r.wb_valid = 1; r.wb_reg = mw.dst; r.wb_data = mwv;
      regs[mw.dst] = mwv;
    end
    nmw = '{regwrite: em.regwrite, memtoreg: em.memtoreg, rdata: 0, alu: em.alu, dst: em.dst};
    idx = em.alu >> 2;
    if (em.branch && em.alu == 0) taken = 1;
    else if (em.memread) nmw.rdata = (idx < 8) ? dmem[idx] : 32'd0;
    else if (em.memwrite && idx < 8) begin
      dmem[idx] = em.wdata;
      r.store_valid = 1; r.store_index = idx[2:0]; r.store_data = em.wdata;
    end
    a = de.rd1;
    b = de.rd2;
    if (em.regwrite && em.dst != 0 && em.dst == de.rs) a = em.alu;
    else if (mw.regwrite && mw.dst != 0 && mw.dst == de.rs) a = mwv;
    if (em.regwrite && em.dst != 0 && em.dst == de.rt) b = em.alu;
    else if (mw.regwrite && mw.dst != 0 && mw.dst == de.rt) b = mwv;
    nem.regwrite = de.regwrite; nem.memtoreg = de.memtoreg; nem.memread = de.memread;
    nem.memwrite = de.memwrite; nem.branch = de.branch;
    nem.alu = alu_calc(de.aluctl, a, de.alusrc ? de.imm : b);
    nem.wdata = b;
    nem.dst = de.regdst ? de.rd : de.rt;
    nem.target = de.pc4 + {de.imm[13:0], 2'b00};
    if (de.memread && de.rt != 0 && fd.fv)
      stall = (de.rt == fd.finstr[25:21]) || (de.rt == fd.finstr[20:16]);
    nde = decode_word(fd);
    if (taken) begin
      stall = 0;
      pc = em.target;
      fd = '{default: '0};
      nde = '{default: '0};
      nem = '{default: '0};
    end else if (stall) begin
      nde = '{default: '0};
    end else begin
      fd.fv = present;
      fd.finstr = present ? word : 32'd0;
      fd.fpc4 = pc + 16'd4;
      pc = fd.fpc4;
    end
    de = nde;
    em = nem;
    mw = nmw;
    r.fetch_addr = pc;
    r.stall_res = stall;
    r.branch_taken = taken;
    expected_q.push_back(r);
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      pc = 0;
      fd = '{default: '0};
      de = '{default: '0};
      em = '{default: '0};
      mw = '{default: '0};
      for (int i = 0; i < 32; i++) regs[i] = reg_init(i);
      for (int i = 0; i < 8; i++) dmem[i] = mem_init(i);
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[91:0];
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (got.fetch_addr !== want.fetch_addr)
              $error("fetch_addr expected %h actual %h", want.fetch_addr, got.fetch_addr);
            if (got.stall_res !== want.stall_res)
              $error("stall_res expected %b actual %b", want.stall_res, got.stall_res);
            if (got.branch_taken !== want.branch_taken)
              $error("branch_taken expected %b actual %b", want.branch_taken, got.branch_taken);
            if (got.wb_valid !== want.wb_valid)
              $error("wb_valid expected %b actual %b", want.wb_valid, got.wb_valid);
            if (got.wb_reg !== want.wb_reg)
              $error("wb_reg expected %0d actual %0d", want.wb_reg, got.wb_reg);
            if (got.wb_data !== want.wb_data)
              $error("wb_data expected %h actual %h", want.wb_data, got.wb_data);
            if (got.store_valid !== want.store_valid)
              $error("store_valid expected %b actual %b", want.store_valid, got.store_valid);
            if (got.store_index !== want.store_index)
              $error("store_index expected %0d actual %0d", want.store_index, got.store_index);
            if (got.store_data !== want.store_data)
              $error("store_data expected %h actual %h", want.store_data, got.store_data);
          end
        end
      end
      if (in_tvalid && in_tready) advance_cycle(in_tdata, in_tuser);
    end
  end
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Testbench top: drives instruction transactions into the pipeline and gives the verdict.
`default_nettype none
module testbench;
  import mfsp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  int          fail_count;
  int          pending;
  int          hold_cycles;

  mips_five_stage_pipeline dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  pipeline_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [31:0] rtype(logic [4:0] rs, rt, rd, logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 9));
  endfunction

  function automatic logic [31:0] random_instr();
    logic [5:0] fns [5];
    logic [15:0] imm;
    fns = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT};
    case ($urandom_range(0, 9))
      0, 1, 2: return rtype(pick_reg(), pick_reg(), pick_reg(), fns[$urandom_range(0, 4)]);
      3, 4: begin
        imm = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11) * 4);
        return itype(OP_LW, ($urandom_range(0, 1) ? 5'd0 : pick_reg()), pick_reg(), imm);
      end
      5, 6: begin
        imm = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9) * 4);
        return itype(OP_SW, ($urandom_range(0, 1) ? 5'd0 : pick_reg()), pick_reg(), imm);
      end
      7: begin
        imm = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 12)) - 6);
        return itype(OP_BEQ, pick_reg(), pick_reg(), imm);
      end
      8: return $urandom;
      default: return rtype(pick_reg(), pick_reg(), pick_reg(), 6'($urandom));
    endcase
  endfunction

  task automatic send(input logic [31:0] word, input logic present);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= present;
    do @(posedge clk); while (!in_tready);
  endtask

  // receiver: random stalls, plus one long hold-off requested by the stimulus
  initial begin
    int gap;
    bit held;
    out_tready = 1'b0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0 && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
      end
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    int waited;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    hold_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each op, forwarding, load-use, beq taken and not, dropped writes
    send(rtype(5'd1, 5'd2, 5'd10, FN_ADD), 1);
    send(rtype(5'd10, 5'd3, 5'd11, FN_SUB), 1);
    send(rtype(5'd11, 5'd10, 5'd12, FN_AND), 1);
    send(rtype(5'd1, 5'd4, 5'd13, FN_OR), 1);
    send(rtype(5'd11, 5'd1, 5'd14, FN_SLT), 1);
    send(rtype(5'd1, 5'd2, 5'd0, FN_ADD), 1);
    send(itype(OP_LW, 5'd0, 5'd15, 16'd4), 1);
    send(rtype(5'd15, 5'd15, 5'd16, FN_ADD), 1);
    send(itype(OP_SW, 5'd0, 5'd16, 16'd28), 1);
    send(itype(OP_SW, 5'd0, 5'd1, 16'hfffc), 1);
    send(itype(OP_LW, 5'd0, 5'd17, 16'd400), 1);
    send(32'hffff_ffff, 1);
    send(32'h0000_0000, 0);
    send(rtype(5'd31, 5'd31, 5'd31, 6'h3f), 1);
    send(itype(OP_BEQ, 5'd0, 5'd0, 16'h7fff), 1);
    send(rtype(5'd1, 5'd1, 5'd18, FN_ADD), 1);
    send(rtype(5'd1, 5'd1, 5'd19, FN_ADD), 1);
    send(rtype(5'd1, 5'd1, 5'd20, FN_ADD), 1);
    send(itype(OP_BEQ, 5'd1, 5'd2, 16'h8000), 1);
    send(itype(OP_BEQ, 5'd0, 5'd0, 16'hfff0), 1);
    repeat (4) send(32'h0, 0);

    // pause until drained, then flood while the receiver holds off
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    hold_cycles = 40;
    for (int i = 0; i < 30; i++) send(random_instr(), 1);
    for (int i = 0; i < 1750; i++) send(random_instr(), $urandom_range(0, 7) != 0);
    in_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> mips_five_stage_pipeline.f
rtl/core/mfsp_pkg.sv
rtl/core/mips_five_stage_pipeline.sv
tb/sv/pipeline_checker.sv
tb/sv/testbench.sv
